### rtl/fta_pkg.sv
// Shared constants and helpers for the fixed-point to decimal ASCII converter.
// No dependencies; every other file but fta_queue refers to it by scoped names.
package fta_pkg;

   localparam int DEF_MAX_CHARS  = 16;
   localparam int DEF_VALUE_BITS = 32;
   localparam int DEF_FRAC_BITS  = 16;

   localparam int IN_W        = 32;  // width of the input value port
   localparam int CHAR_W      = 7;
   localparam int FRAC_H_W    = 7;   // two truncated fraction digits as 0..99
   localparam int QUEUE_DEPTH = 2;

   localparam logic [CHAR_W-1:0] CH_MINUS = 7'd45;
   localparam logic [CHAR_W-1:0] CH_DOT   = 7'd46;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 7'd48;

   // Tens digit of a value in 0..99 by parallel compares.
   function automatic logic [3:0] div10(input logic [FRAC_H_W-1:0] h);
      logic [3:0] q;
      q = 4'd0;
      for (int k = 1; k < 10; k++) begin
         if (h >= FRAC_H_W'(10 * k)) q = 4'(k);
      end
      return q;
   endfunction

endpackage

### rtl/fixed_to_decimal_ascii.sv
// Top level: fixed-point value in, decimal ASCII characters out.
// Instantiates fta_front, fta_queue and fta_back; uses fta_pkg.
//
//   channel  ports                               transfer when
//   req      req_push req_full req_value         req_push && !req_full
//   rsp      rsp_pop rsp_empty rsp_char_code     rsp_pop && !rsp_empty
//            rsp_last
//
// Per value the engine takes it from the queue, converts the integer part
// with the shift-and-add-3 converter (IW = VALUE_BITS - FRAC_BITS, 16 by
// default), runs a setup step, then emits one character per cycle while the
// result register is free. A two-entry queue takes new values while the
// engine works; a full result register stalls only
// the engine. Synchronous reset empties the queue and the result register.
module fixed_to_decimal_ascii #(
   parameter int MAX_CHARS  = fta_pkg::DEF_MAX_CHARS,
   parameter int VALUE_BITS = fta_pkg::DEF_VALUE_BITS,
   parameter int FRAC_BITS  = fta_pkg::DEF_FRAC_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic [fta_pkg::IN_W-1:0]     req_value,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output logic [fta_pkg::CHAR_W-1:0]   rsp_char_code,
   output logic                         rsp_last
);

   localparam int IW = VALUE_BITS - FRAC_BITS;
   localparam int HW = fta_pkg::FRAC_H_W;
   localparam int EW = 1 + IW + HW + 1;

   logic          f_neg, f_frac_nz;
   logic [IW-1:0] f_ipart;
   logic [HW-1:0] f_frac_h;
   logic [EW-1:0] q_wr_data, q_rd_data;
   logic          q_empty, q_pop;

   fta_front #(
      .VALUE_BITS(VALUE_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .value  (req_value),
      .neg    (f_neg),
      .ipart  (f_ipart),
      .frac_h (f_frac_h),
      .frac_nz(f_frac_nz)
   );

   assign q_wr_data = {f_neg, f_ipart, f_frac_h, f_frac_nz};

   fta_queue #(
      .WIDTH(EW),
      .DEPTH(fta_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (req_push),
      .wr_data(q_wr_data),
      .full   (req_full),
      .pop    (q_pop),
      .rd_data(q_rd_data),
      .empty  (q_empty)
   );

   fta_back #(
      .MAX_CHARS (MAX_CHARS),
      .VALUE_BITS(VALUE_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_empty      (q_empty),
      .q_pop        (q_pop),
      .q_neg        (q_rd_data[EW-1]),
      .q_ipart      (q_rd_data[EW-2 -: IW]),
      .q_frac_h     (q_rd_data[HW:1]),
      .q_frac_nz    (q_rd_data[0]),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_char_code(rsp_char_code),
      .rsp_last     (rsp_last)
   );

endmodule

### rtl/fta_front.sv
// Input classifier: sign, magnitude, integer part and fraction digits of one value.
// Uses fta_pkg.
module fta_front #(
   parameter int VALUE_BITS = fta_pkg::DEF_VALUE_BITS,
   parameter int FRAC_BITS  = fta_pkg::DEF_FRAC_BITS
) (
   input  logic [fta_pkg::IN_W-1:0]        value,
   output logic                            neg,
   output logic [VALUE_BITS-FRAC_BITS-1:0] ipart,
   output logic [fta_pkg::FRAC_H_W-1:0]    frac_h,
   output logic                            frac_nz
);

   localparam int PW = FRAC_BITS + fta_pkg::FRAC_H_W;

   logic [VALUE_BITS-1:0] raw;
   logic [VALUE_BITS-1:0] mag;
   logic [PW-1:0]         prod;

   if (VALUE_BITS <= fta_pkg::IN_W) begin : g_trunc
      assign raw = value[VALUE_BITS-1:0];
   end else begin : g_ext
      assign raw = {{(VALUE_BITS-fta_pkg::IN_W){1'b0}}, value};
   end

   // Most negative value negates to itself, which read unsigned is its magnitude.
   assign neg     = raw[VALUE_BITS-1];
   assign mag     = neg ? (~raw + VALUE_BITS'(1)) : raw;
   assign ipart   = mag[VALUE_BITS-1:FRAC_BITS];
   assign frac_nz = |mag[FRAC_BITS-1:0];
   assign prod    = PW'(mag[FRAC_BITS-1:0]) * PW'(100);
   assign frac_h  = prod[PW-1:FRAC_BITS];

endmodule

### rtl/fta_queue.sv
// Small register queue between the classifier and the digit engine.
// No package dependencies.
module fta_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             push_ok, pop_ok;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign push_ok = push && !full;
   assign pop_ok  = pop && !empty;
   assign rd_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (push_ok && !pop_ok) count_in = count_ff + CW'(1);
      else if (pop_ok && !push_ok) count_in = count_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push_ok) slot_ff[wr_ptr_ff] <= wr_data;
   end

endmodule

### rtl/fta_back.sv
// Digit engine: shift-and-add-3 binary to BCD, then character sequencer
// feeding the result register. Uses fta_pkg.
module fta_back #(
   parameter int MAX_CHARS  = fta_pkg::DEF_MAX_CHARS,
   parameter int VALUE_BITS = fta_pkg::DEF_VALUE_BITS,
   parameter int FRAC_BITS  = fta_pkg::DEF_FRAC_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             q_empty,
   output logic                             q_pop,
   input  logic                             q_neg,
   input  logic [VALUE_BITS-FRAC_BITS-1:0]  q_ipart,
   input  logic [fta_pkg::FRAC_H_W-1:0]     q_frac_h,
   input  logic                             q_frac_nz,
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output logic [fta_pkg::CHAR_W-1:0]       rsp_char_code,
   output logic                             rsp_last
);

   localparam int IW    = VALUE_BITS - FRAC_BITS;
   localparam int IW2   = IW + (IW % 2);          // even width: bits are shifted in pairs
   localparam int STEPS = IW2 / 2;
   localparam int SW    = (STEPS > 1) ? $clog2(STEPS) : 1;
   localparam int ND    = (IW * 30103) / 100000 + 1;
   localparam int DIW   = (ND > 1) ? $clog2(ND) : 1;
   localparam int NW    = $clog2(ND + 1);
   localparam int KW    = $clog2(MAX_CHARS + ND + 4) + 1;
   localparam int HW    = fta_pkg::FRAC_H_W;
   localparam int CHW   = fta_pkg::CHAR_W;

   typedef enum logic [2:0] {
      S_IDLE, S_CONV, S_PREP, S_SIGN, S_INT, S_DOT, S_D1, S_D2
   } state_type;

   state_type            state_ff, state_in;
   logic [IW2-1:0]       bin_ff, bin_in;
   logic [ND-1:0][3:0]   bcd_ff, bcd_in;
   logic [SW-1:0]        cyc_ff, cyc_in;
   logic                 neg_ff, neg_in;
   logic [HW-1:0]        frac_h_ff, frac_h_in;
   logic                 frac_nz_ff, frac_nz_in;
   logic                 frac_on_ff, frac_on_in;
   logic [DIW-1:0]       di_ff, di_in;
   logic [KW-1:0]        int_left_ff, int_left_in;
   logic                 out_valid_ff, out_valid_in;
   logic [CHW-1:0]       char_ff, char_in;
   logic                 last_ff, last_in;

   logic [ND-1:0][3:0]   dd_bcd;
   logic [IW2-1:0]       dd_bin;
   logic [NW-1:0]        nsig;
   logic [KW-1:0]        avail, nint;
   logic                 cut, fon;
   logic [3:0]           d1;
   logic [HW-1:0]        rem;
   logic                 out_free;

   // two shift-and-add-3 steps per cycle
   always_comb begin
      dd_bcd = bcd_ff;
      dd_bin = bin_ff;
      for (int s = 0; s < 2; s++) begin
         for (int d = 0; d < ND; d++) begin
            if (dd_bcd[d] >= 4'd5) dd_bcd[d] = dd_bcd[d] + 4'd3;
         end
         {dd_bcd, dd_bin} = {dd_bcd, dd_bin} << 1;
      end
   end

   // significant integer digits; a zero integer part still prints one '0'
   always_comb begin
      nsig = NW'(1);
      for (int d = 0; d < ND; d++) begin
         if (bcd_ff[d] != 4'd0) nsig = NW'(d + 1);
      end
   end

   assign avail = KW'(MAX_CHARS) - KW'(neg_ff);
   assign cut   = KW'(nsig) > avail;
   assign nint  = cut ? avail : KW'(nsig);
   assign fon   = frac_nz_ff && !cut &&
                  (KW'(neg_ff) + KW'(nsig) + KW'(3) <= KW'(MAX_CHARS));

   assign d1  = fta_pkg::div10(frac_h_ff);
   assign rem = frac_h_ff - HW'(d1) * HW'(10);

   assign out_free      = !out_valid_ff || rsp_pop;
   assign q_pop         = (state_ff == S_IDLE) && !q_empty;
   assign rsp_empty     = !out_valid_ff;
   assign rsp_char_code = char_ff;
   assign rsp_last      = last_ff;

   always_comb begin
      state_in     = state_ff;
      bin_in       = bin_ff;
      bcd_in       = bcd_ff;
      cyc_in       = cyc_ff;
      neg_in       = neg_ff;
      frac_h_in    = frac_h_ff;
      frac_nz_in   = frac_nz_ff;
      frac_on_in   = frac_on_ff;
      di_in        = di_ff;
      int_left_in  = int_left_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      char_in      = char_ff;
      last_in      = last_ff;
      case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               bin_in     = IW2'(q_ipart);
               bcd_in     = '0;
               cyc_in     = '0;
               neg_in     = q_neg;
               frac_h_in  = q_frac_h;
               frac_nz_in = q_frac_nz;
               state_in   = S_CONV;
            end
         end
         S_CONV: begin
            bin_in = dd_bin;
            bcd_in = dd_bcd;
            cyc_in = cyc_ff + SW'(1);
            if (cyc_ff == SW'(STEPS - 1)) state_in = S_PREP;
         end
         S_PREP: begin
            di_in       = DIW'(nsig - NW'(1));
            int_left_in = nint;
            frac_on_in  = fon;
            state_in    = neg_ff ? S_SIGN : S_INT;
         end
         S_SIGN: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               char_in      = fta_pkg::CH_MINUS;
               last_in      = 1'b0;
               state_in     = S_INT;
            end
         end
         S_INT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               char_in      = fta_pkg::CH_ZERO + CHW'(bcd_ff[di_ff]);
               last_in      = (int_left_ff == KW'(1)) && !frac_on_ff;
               di_in        = di_ff - DIW'(1);
               int_left_in  = int_left_ff - KW'(1);
               if (int_left_ff == KW'(1)) state_in = frac_on_ff ? S_DOT : S_IDLE;
            end
         end
         S_DOT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               char_in      = fta_pkg::CH_DOT;
               last_in      = 1'b0;
               state_in     = S_D1;
            end
         end
         S_D1: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               char_in      = fta_pkg::CH_ZERO + CHW'(d1);
               last_in      = 1'b0;
               state_in     = S_D2;
            end
         end
         S_D2: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               char_in      = fta_pkg::CH_ZERO + CHW'(rem[3:0]);
               last_in      = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      bin_ff      <= bin_in;
      bcd_ff      <= bcd_in;
      cyc_ff      <= cyc_in;
      neg_ff      <= neg_in;
      frac_h_ff   <= frac_h_in;
      frac_nz_ff  <= frac_nz_in;
      frac_on_ff  <= frac_on_in;
      di_ff       <= di_in;
      int_left_ff <= int_left_in;
      char_ff     <= char_in;
      last_ff     <= last_in;
   end

endmodule

### sim/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for fixed_to_decimal_ascii: values in, decimal text checked
// character by character against an in-bench text predictor. Depends on fta_pkg.
module tb;

   localparam int MAX_CHARS   = fta_pkg::DEF_MAX_CHARS;
   localparam int VALUE_BITS  = fta_pkg::DEF_VALUE_BITS;
   localparam int FRAC_BITS   = fta_pkg::DEF_FRAC_BITS;
   localparam int N_RANDOM    = 140;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_WAIT  = 60;

   typedef logic [fta_pkg::IN_W-1:0] value_type;
   typedef struct packed {
      logic [fta_pkg::CHAR_W-1:0] code;
      logic                       last;
   } text_char_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_push = 1'b0;
   logic                        req_full;
   value_type                   req_value = '0;
   logic                        rsp_empty;
   logic                        rsp_pop = 1'b0;
   logic [fta_pkg::CHAR_W-1:0]  rsp_char_code;
   logic                        rsp_last;

   value_type     pending_values[$];
   text_char_type expected_text[$];

   int  error_count = 0;
   int  values_sent = 0;
   int  values_taken = 0;
   int  chars_checked = 0;
   int  negatives_taken = 0;
   int  cycle_count = 0;
   int  push_gap = 0;
   int  pop_gap = 0;
   bit  push_taken = 1'b0;
   bit  pop_taken = 1'b0;

   fixed_to_decimal_ascii DUT (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_value    (req_value),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_char_code(rsp_char_code),
      .rsp_last     (rsp_last)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Mostly short gaps, a few long ones; none at all while quiet.
   function automatic int pick_gap(input bit quiet);
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      return $urandom_range(5, 40);
   endfunction

   // Appends the expected characters of one value's text.
   function automatic void predict_text(input value_type v);
      logic [63:0]   vmask, raw, mag, ipart, frac, d1, d2;
      logic [3:0]    digits[24];
      text_char_type txt[$];
      int            nd;
      bit            neg, cut;
      vmask = (64'd1 << VALUE_BITS) - 64'd1;
      raw   = 64'(v) & vmask;
      neg   = raw[VALUE_BITS-1];
      mag   = neg ? (((64'd1 << VALUE_BITS) - raw) & vmask) : raw;
      if (neg && mag == 64'd0) mag = 64'd1 << (VALUE_BITS - 1);
      ipart = mag >> FRAC_BITS;
      frac  = mag & ((64'd1 << FRAC_BITS) - 64'd1);
      nd  = 0;
      cut = 1'b0;
      if (neg) txt.push_back('{code: fta_pkg::CH_MINUS, last: 1'b0});
      if (ipart == 64'd0) begin
         txt.push_back('{code: fta_pkg::CH_ZERO, last: 1'b0});
      end else begin
         while (ipart != 64'd0 && nd < 24) begin
            digits[nd] = 4'(ipart % 64'd10);
            ipart = ipart / 64'd10;
            nd++;
         end
         // most significant first; the tail is dropped once the text is full
         while (nd > 0 && !cut) begin
            if (txt.size() >= MAX_CHARS) begin
               cut = 1'b1;
            end else begin
               nd--;
               txt.push_back('{code: fta_pkg::CH_ZERO + 7'(digits[nd]), last: 1'b0});
            end
         end
      end
      if (frac != 64'd0 && !cut && txt.size() + 3 <= MAX_CHARS) begin
         d1 = (frac * 64'd10) >> FRAC_BITS;
         d2 = ((frac * 64'd100) >> FRAC_BITS) % 64'd10;
         txt.push_back('{code: fta_pkg::CH_DOT, last: 1'b0});
         txt.push_back('{code: fta_pkg::CH_ZERO + 7'(d1), last: 1'b0});
         txt.push_back('{code: fta_pkg::CH_ZERO + 7'(d2), last: 1'b0});
      end
      txt[txt.size()-1].last = 1'b1;
      foreach (txt[i]) expected_text.push_back(txt[i]);
   endfunction

   task automatic report_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   // Driver: feeds pending values, holds each until its transfer.
   always @(negedge clock) begin
      if (!reset) begin
         if (!(req_push && !push_taken)) begin
            if (push_gap > 0) begin
               push_gap <= push_gap - 1;
               req_push <= 1'b0;
            end else if (pending_values.size() > 0) begin
               req_value <= pending_values.pop_front();
               req_push  <= 1'b1;
               push_gap  <= pick_gap((values_sent / 32) % 3 == 1);
               values_sent++;
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // Receiver side: pop with random stalls.
   always @(negedge clock) begin
      if (!reset) begin
         if (!(rsp_pop && !pop_taken)) begin
            if (pop_gap > 0) begin
               pop_gap <= pop_gap - 1;
               rsp_pop <= 1'b0;
            end else begin
               rsp_pop <= 1'b1;
               pop_gap <= pick_gap((chars_checked / 64) % 3 == 2);
            end
         end
      end
   end

   // Monitor: checks each result transfer, then predicts for each input transfer.
   always @(posedge clock) begin
      text_char_type want;
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d characters still expected",
                  cycle_count, expected_text.size());
         $display("Test completed with failures");
         $finish;
      end
      push_taken <= !reset && req_push && !req_full;
      pop_taken  <= !reset && rsp_pop && !rsp_empty;
      if (!reset) begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_text.size() == 0) begin
               report_mismatch($sformatf("unexpected char 0x%02h last=%0b",
                                         rsp_char_code, rsp_last));
            end else begin
               want = expected_text.pop_front();
               if (rsp_char_code !== want.code)
                  report_mismatch($sformatf("char_code 0x%02h, expected 0x%02h",
                                            rsp_char_code, want.code));
               if (rsp_last !== want.last)
                  report_mismatch($sformatf("last %0b, expected %0b (char 0x%02h)",
                                            rsp_last, want.last, want.code));
            end
            chars_checked++;
         end
         if (req_push && !req_full) begin
            predict_text(req_value);
            values_taken++;
            if (req_value[VALUE_BITS-1]) negatives_taken++;
         end
      end
   end

   initial begin
      value_type v;
      // extremes, zero, sub-one magnitudes of both signs, truncation corners
      pending_values = '{
         32'h0000_0000, 32'h0000_0001, 32'h0001_0000, 32'h7FFF_FFFF,
         32'h8000_0000, 32'h8000_0001, 32'hFFFF_FFFF, 32'hFFFF_8000,
         32'h0000_8000, 32'h000A_0000, 32'h0009_FFFF, 32'h0064_0000,
         32'hFFFF_0000, 32'h0000_0CCC, 32'h7FFF_0000, 32'h0000_FFFF,
         32'h5555_AAAA, 32'hAAAA_5555, 32'h0000_199A, 32'hFFFF_E666
      };
      for (int i = 0; i < N_RANDOM; i++) begin
         case ($urandom_range(0, 3))
            0: v = $urandom();
            1: v = {16'($urandom_range(0, 999)), 16'($urandom())};
            2: v = {16'($urandom()), 16'h0000};
            default: v = {16'h0000, 16'($urandom())};
         endcase
         if ($urandom_range(0, 2) == 0) v = -v;
         pending_values.push_back(v);
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      wait (pending_values.size() == 0 && !req_push);
      wait (expected_text.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      $display("Converted %0d values (%0d negative), checked %0d characters",
               values_taken, negatives_taken, chars_checked);
      if (error_count == 0 && expected_text.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
